FILE: design/stcx_pkg.sv
// ----------------------------------------------------------------------------
// stcx_pkg
// Shared types, constants and helpers of the space-time successor expander.
// ----------------------------------------------------------------------------
package stcx_pkg;

    localparam int GRID_SIDE_DEF  = 16;
    localparam int MAX_AGENTS_DEF = 8;
    localparam int TRAJ_LEN_DEF   = 256;

    localparam int COORD_W   = 4;
    localparam int TIME_W    = 10;
    localparam int AGENT_W   = 3;
    localparam int LENV_W    = 9;
    localparam int LEN_SAT_W = 11;   // holds any saturated length up to 1024
    localparam int EST_W     = 6;
    localparam int SIZE_W    = 5;
    localparam int DELTA_W   = 3;
    localparam int ACNT_W    = 4;
    localparam int PT_W      = 3 * COORD_W;
    localparam int STEP_W    = 4;    // window step, 0 .. 2*delta
    localparam int WIN_W     = TIME_W + 1;
    localparam int SUM_W     = 7;
    localparam int QDEPTH    = 2;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [SUM_W-1:0]  EST_MAX  = SUM_W'(63);

    typedef enum logic [1:0] {
        KIND_OBS    = 2'd0,
        KIND_POINT  = 2'd1,
        KIND_LEN    = 2'd2,
        KIND_EXPAND = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_SIZE_X  = 3'd0,
        REG_SIZE_Y  = 3'd1,
        REG_SIZE_Z  = 3'd2,
        REG_DELTA   = 3'd3,
        REG_AGENTS  = 3'd4,
        REG_GOAL_X  = 3'd5,
        REG_GOAL_Y  = 3'd6,
        REG_GOAL_Z  = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        MV_XN    = 3'd0,
        MV_XP    = 3'd1,
        MV_YN    = 3'd2,
        MV_YP    = 3'd3,
        MV_ZN    = 3'd4,
        MV_ZP    = 3'd5,
        MV_HOVER = 3'd6
    } move_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NBR,
        ST_OBS,
        ST_SCAN,
        ST_EMIT,
        ST_FINISH
    } bstate_t;

    typedef struct packed {
        kind_t               kind;
        logic [COORD_W-1:0]  pos_x;
        logic [COORD_W-1:0]  pos_y;
        logic [COORD_W-1:0]  pos_z;
        logic [TIME_W-1:0]   time_index;
        logic [AGENT_W-1:0]  agent;
        logic                blocked_bit;
        logic [LENV_W-1:0]   length_value;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0]  succ_x;
        logic [COORD_W-1:0]  succ_y;
        logic [COORD_W-1:0]  succ_z;
        logic [TIME_W-1:0]   succ_time;
        logic                is_hover;
        logic                found;
        logic [EST_W-1:0]    estimate;
        logic                last;
    } out_item_t;

    typedef struct packed {
        logic [SIZE_W-1:0]   size_x;
        logic [SIZE_W-1:0]   size_y;
        logic [SIZE_W-1:0]   size_z;
        logic [DELTA_W-1:0]  window_delta;
        logic [ACNT_W-1:0]   agent_count;
        logic [COORD_W-1:0]  goal_x;
        logic [COORD_W-1:0]  goal_y;
        logic [COORD_W-1:0]  goal_z;
    } cfg_t;

    // classified command handed from front to back
    typedef struct packed {
        kind_t                kind;
        logic                 wr_ok;
        logic [COORD_W-1:0]   pos_x;
        logic [COORD_W-1:0]   pos_y;
        logic [COORD_W-1:0]   pos_z;
        logic [TIME_W-1:0]    time_index;
        logic [TIME_W-1:0]    succ_time;
        logic [AGENT_W-1:0]   agent;
        logic                 blocked_bit;
        logic [LEN_SAT_W-1:0] length;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    function automatic logic [COORD_W:0] absdiff(input logic [COORD_W:0] a,
                                                 input logic [COORD_W:0] b);
        absdiff = (a > b) ? a - b : b - a;
    endfunction

endpackage

FILE: design/stcx_ram.sv
// ----------------------------------------------------------------------------
// stcx_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module stcx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/stcx_queue.sv
// ----------------------------------------------------------------------------
// stcx_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module stcx_queue
    import stcx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t       entry_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full       = (count_reg == 2'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

endmodule

FILE: design/stcx_front.sv
// ----------------------------------------------------------------------------
// stcx_front
// Accepts items, range-checks load writes, saturates time and length.
// ----------------------------------------------------------------------------
module stcx_front
    import stcx_pkg::*;
#(
    parameter int GRID_SIDE  = GRID_SIDE_DEF,
    parameter int MAX_AGENTS = MAX_AGENTS_DEF,
    parameter int TRAJ_LEN   = TRAJ_LEN_DEF
) (
    input  logic         node_valid,
    output logic         node_ready,
    input  in_item_t     node,
    input  logic         q_full,
    input  back_status_t status,
    output logic         push,
    output cmd_t         push_cmd
);

    logic in_grid;
    logic agent_ok;
    logic step_ok;

    always_comb
    begin
        in_grid  = (32'(node.pos_x) < GRID_SIDE) && (32'(node.pos_y) < GRID_SIDE)
                && (32'(node.pos_z) < GRID_SIDE);
        agent_ok = 32'(node.agent) < MAX_AGENTS;
        step_ok  = 32'(node.time_index) < TRAJ_LEN;

        push_cmd.kind        = node.kind;
        push_cmd.pos_x       = node.pos_x;
        push_cmd.pos_y       = node.pos_y;
        push_cmd.pos_z       = node.pos_z;
        push_cmd.time_index  = node.time_index;
        push_cmd.agent       = node.agent;
        push_cmd.blocked_bit = node.blocked_bit;
        push_cmd.succ_time   = (node.time_index == TIME_MAX) ? TIME_MAX
                             : node.time_index + TIME_W'(1);
        push_cmd.length      = (32'(node.length_value) > TRAJ_LEN)
                             ? LEN_SAT_W'(TRAJ_LEN) : LEN_SAT_W'(node.length_value);
        case (node.kind)
            KIND_OBS:   push_cmd.wr_ok = in_grid;
            KIND_POINT: push_cmd.wr_ok = agent_ok && step_ok;
            KIND_LEN:   push_cmd.wr_ok = agent_ok;
            default:    push_cmd.wr_ok = 1'b1;
        endcase
    end

    // hold off items while the obstacle map is swept after reset
    assign node_ready = !q_full && !status.clearing;
    assign push       = node_valid && node_ready;

endmodule

FILE: design/stcx_back.sv
// ----------------------------------------------------------------------------
// stcx_back
// Executes commands: load writes, obstacle sweep, neighbor expansion with the
// trajectory window scan, and the output register.
// ----------------------------------------------------------------------------
module stcx_back
    import stcx_pkg::*;
#(
    parameter int GRID_SIDE  = GRID_SIDE_DEF,
    parameter int MAX_AGENTS = MAX_AGENTS_DEF,
    parameter int TRAJ_LEN   = TRAJ_LEN_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         q_valid,
    input  cmd_t         q_cmd,
    output logic         q_pop,
    output back_status_t status,
    output logic         succ_valid,
    input  logic         succ_ready,
    output out_item_t    succ
);

    localparam int OBS_DEPTH = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int OBS_AW    = $clog2(OBS_DEPTH);
    localparam int AIW       = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
    localparam int ANW       = $clog2(MAX_AGENTS + 1);
    localparam int IDX_W     = $clog2(TRAJ_LEN);
    localparam int LEN_W     = $clog2(TRAJ_LEN + 1);
    localparam int TP_DEPTH  = MAX_AGENTS * TRAJ_LEN;
    localparam int TP_AW     = $clog2(TP_DEPTH);
    localparam int GCLOG     = $clog2(GRID_SIDE + 1);
    localparam int GCW       = ((SIZE_W > GCLOG) ? SIZE_W : GCLOG) + 1;
    localparam int NW        = COORD_W + 1;

    bstate_t             state_reg, state_next;
    logic [OBS_AW-1:0]   clr_addr_reg, clr_addr_next;
    cmd_t                node_reg, node_next;
    move_t               m_reg, m_next;
    logic [NW-1:0]       nbr_x_reg, nbr_x_next;
    logic [NW-1:0]       nbr_y_reg, nbr_y_next;
    logic [NW-1:0]       nbr_z_reg, nbr_z_next;
    logic [ANW-1:0]      a_reg, a_next;
    logic [STEP_W-1:0]   k_reg, k_next;
    logic                pend_reg, pend_next;
    logic [LEN_W-1:0]    lens_reg [MAX_AGENTS];
    logic [LEN_W-1:0]    lens_next [MAX_AGENTS];
    out_item_t           held_reg, held_next;
    logic                held_vld_reg, held_vld_next;
    out_item_t           out_reg, out_next;
    logic                out_vld_reg, out_vld_next;

    logic [NW-1:0]       cand_x, cand_y, cand_z;
    logic                under;
    logic                in_grid;
    logic [GCW-1:0]      sx, sy, sz;
    logic [ANW-1:0]      n_agents;
    logic [AIW-1:0]      a_idx;
    logic [LEN_W-1:0]    cur_len;
    logic [WIN_W-1:0]    wsum, w;
    logic                w_neg;
    logic [IDX_W-1:0]    idx;
    logic                k_last;
    logic                scan_done;
    logic                hit;
    logic                issue;
    logic                out_free;
    logic                last_move;
    move_t               m_adv;
    logic [SUM_W-1:0]    est_sum;
    out_item_t           new_item;

    logic                obs_we, obs_re;
    logic [OBS_AW-1:0]   obs_waddr, obs_raddr;
    logic                obs_wdata;
    logic                obs_rdata;
    logic                tp_we;
    logic [TP_AW-1:0]    tp_waddr, tp_raddr;
    logic [PT_W-1:0]     tp_rdata;

    // ---------------- neighbor and window arithmetic ----------------
    always_comb
    begin
        cand_x = {1'b0, node_reg.pos_x};
        cand_y = {1'b0, node_reg.pos_y};
        cand_z = {1'b0, node_reg.pos_z};
        under  = 1'b0;
        case (m_reg)
            MV_XN:
            begin
                under  = (node_reg.pos_x == '0);
                cand_x = cand_x - NW'(1);
            end
            MV_XP: cand_x = cand_x + NW'(1);
            MV_YN:
            begin
                under  = (node_reg.pos_y == '0);
                cand_y = cand_y - NW'(1);
            end
            MV_YP: cand_y = cand_y + NW'(1);
            MV_ZN:
            begin
                under  = (node_reg.pos_z == '0);
                cand_z = cand_z - NW'(1);
            end
            MV_ZP: cand_z = cand_z + NW'(1);
            default: under = 1'b0;
        endcase

        sx = (GCW'(cfg.size_x) > GCW'(GRID_SIDE)) ? GCW'(GRID_SIDE) : GCW'(cfg.size_x);
        sy = (GCW'(cfg.size_y) > GCW'(GRID_SIDE)) ? GCW'(GRID_SIDE) : GCW'(cfg.size_y);
        sz = (GCW'(cfg.size_z) > GCW'(GRID_SIDE)) ? GCW'(GRID_SIDE) : GCW'(cfg.size_z);
        in_grid = !under && (GCW'(cand_x) < sx) && (GCW'(cand_y) < sy)
               && (GCW'(cand_z) < sz);

        n_agents = (32'(cfg.agent_count) > MAX_AGENTS) ? ANW'(MAX_AGENTS)
                 : ANW'(cfg.agent_count);
        a_idx    = AIW'(a_reg);
        cur_len  = lens_reg[a_idx];

        // window time = succ_time - delta + k; negative times are skipped
        wsum   = WIN_W'(node_reg.succ_time) + WIN_W'(k_reg);
        w_neg  = wsum < WIN_W'(cfg.window_delta);
        w      = wsum - WIN_W'(cfg.window_delta);
        idx    = (w < WIN_W'(cur_len)) ? IDX_W'(w) : IDX_W'(cur_len - LEN_W'(1));
        k_last = (k_reg == STEP_W'({cfg.window_delta, 1'b0}));

        scan_done = (a_reg >= n_agents);
        hit       = pend_reg
                 && (tp_rdata == {nbr_x_reg[COORD_W-1:0], nbr_y_reg[COORD_W-1:0],
                                  nbr_z_reg[COORD_W-1:0]});
        issue     = (state_reg == ST_SCAN) && !scan_done && !hit
                 && (cur_len != '0) && !w_neg;

        out_free  = !out_vld_reg || succ_ready;
        last_move = (m_reg == MV_HOVER);
        m_adv     = move_t'(m_reg + 3'd1);

        est_sum = SUM_W'(absdiff(nbr_x_reg, {1'b0, cfg.goal_x}))
                + SUM_W'(absdiff(nbr_y_reg, {1'b0, cfg.goal_y}))
                + SUM_W'(absdiff(nbr_z_reg, {1'b0, cfg.goal_z}));
        new_item.succ_x    = nbr_x_reg[COORD_W-1:0];
        new_item.succ_y    = nbr_y_reg[COORD_W-1:0];
        new_item.succ_z    = nbr_z_reg[COORD_W-1:0];
        new_item.succ_time = node_reg.succ_time;
        new_item.is_hover  = last_move;
        new_item.found     = 1'b1;
        new_item.estimate  = (est_sum > EST_MAX) ? EST_W'(EST_MAX) : EST_W'(est_sum);
        new_item.last      = 1'b0;

        tp_raddr = TP_AW'(TP_AW'(a_idx) * TP_AW'(TRAJ_LEN)) + TP_AW'(idx);
        tp_waddr = TP_AW'(TP_AW'(q_cmd.agent) * TP_AW'(TRAJ_LEN))
                 + TP_AW'(q_cmd.time_index);
        obs_raddr = OBS_AW'((OBS_AW'(cand_x) * OBS_AW'(GRID_SIDE) + OBS_AW'(cand_y))
                  * OBS_AW'(GRID_SIDE) + OBS_AW'(cand_z));
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_addr_reg == OBS_AW'(OBS_DEPTH - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (q_valid && (q_cmd.kind == KIND_EXPAND))
                    state_next = ST_NBR;
            ST_NBR:
                if (in_grid)
                    state_next = ST_OBS;
                else if (last_move)
                    state_next = ST_FINISH;
            ST_OBS:
                if (!obs_rdata)
                    state_next = ST_SCAN;
                else
                    state_next = last_move ? ST_FINISH : ST_NBR;
            ST_SCAN:
                if (hit)
                    state_next = last_move ? ST_FINISH : ST_NBR;
                else if (scan_done && !pend_reg)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (!held_vld_reg || out_free)
                    state_next = last_move ? ST_FINISH : ST_NBR;
            ST_FINISH:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---------------- datapath and control outputs ----------------
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        node_next     = node_reg;
        m_next        = m_reg;
        nbr_x_next    = nbr_x_reg;
        nbr_y_next    = nbr_y_reg;
        nbr_z_next    = nbr_z_reg;
        a_next        = a_reg;
        k_next        = k_reg;
        pend_next     = issue;
        lens_next     = lens_reg;
        held_next     = held_reg;
        held_vld_next = held_vld_reg;
        out_next      = out_reg;
        out_vld_next  = out_vld_reg && !succ_ready;
        q_pop         = 1'b0;
        obs_we        = 1'b0;
        obs_waddr     = OBS_AW'((OBS_AW'(q_cmd.pos_x) * OBS_AW'(GRID_SIDE)
                      + OBS_AW'(q_cmd.pos_y)) * OBS_AW'(GRID_SIDE) + OBS_AW'(q_cmd.pos_z));
        obs_wdata     = q_cmd.blocked_bit;
        obs_re        = 1'b0;
        tp_we         = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                obs_we        = 1'b1;
                obs_waddr     = clr_addr_reg;
                obs_wdata     = 1'b0;
                clr_addr_next = clr_addr_reg + OBS_AW'(1);
            end
            ST_IDLE:
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.kind)
                        KIND_OBS:   obs_we = q_cmd.wr_ok;
                        KIND_POINT: tp_we  = q_cmd.wr_ok;
                        KIND_LEN:
                            if (q_cmd.wr_ok)
                                lens_next[AIW'(q_cmd.agent)] = LEN_W'(q_cmd.length);
                        default:
                        begin
                            node_next = q_cmd;
                            m_next    = MV_XN;
                        end
                    endcase
                end
            ST_NBR:
            begin
                nbr_x_next = cand_x;
                nbr_y_next = cand_y;
                nbr_z_next = cand_z;
                if (in_grid)
                    obs_re = 1'b1;
                else if (!last_move)
                    m_next = m_adv;
            end
            ST_OBS:
            begin
                a_next = '0;
                k_next = '0;
                if (obs_rdata && !last_move)
                    m_next = m_adv;
            end
            ST_SCAN:
                if (hit)
                begin
                    if (!last_move)
                        m_next = m_adv;
                end
                else if (!scan_done)
                begin
                    if ((cur_len == '0) || k_last)
                    begin
                        a_next = a_reg + ANW'(1);
                        k_next = '0;
                    end
                    else
                        k_next = k_reg + STEP_W'(1);
                end
            ST_EMIT:
                if (!held_vld_reg || out_free)
                begin
                    if (held_vld_reg)
                    begin
                        out_next     = held_reg;
                        out_vld_next = 1'b1;
                    end
                    held_next     = new_item;
                    held_vld_next = 1'b1;
                    if (!last_move)
                        m_next = m_adv;
                end
            ST_FINISH:
                if (out_free)
                begin
                    out_next      = held_vld_reg ? held_reg : '0;
                    out_next.last = 1'b1;
                    out_vld_next  = 1'b1;
                    held_vld_next = 1'b0;
                end
            default:
                q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            m_reg        <= MV_XN;
            a_reg        <= '0;
            k_reg        <= '0;
            pend_reg     <= 1'b0;
            held_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            for (int i = 0; i < MAX_AGENTS; i++)
            begin
                lens_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_reg        <= m_next;
            a_reg        <= a_next;
            k_reg        <= k_next;
            pend_reg     <= pend_next;
            held_vld_reg <= held_vld_next;
            out_vld_reg  <= out_vld_next;
            lens_reg     <= lens_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        nbr_x_reg <= nbr_x_next;
        nbr_y_reg <= nbr_y_next;
        nbr_z_reg <= nbr_z_next;
        held_reg  <= held_next;
        out_reg   <= out_next;
    end

    stcx_ram #(
        .WIDTH (1),
        .DEPTH (OBS_DEPTH)
    ) u_obs_ram (
        .clk   (clk),
        .we    (obs_we),
        .waddr (obs_waddr),
        .wdata (obs_wdata),
        .re    (obs_re),
        .raddr (obs_raddr),
        .rdata (obs_rdata)
    );

    stcx_ram #(
        .WIDTH (PT_W),
        .DEPTH (TP_DEPTH)
    ) u_traj_ram (
        .clk   (clk),
        .we    (tp_we),
        .waddr (tp_waddr),
        .wdata ({q_cmd.pos_x, q_cmd.pos_y, q_cmd.pos_z}),
        .re    (issue),
        .raddr (tp_raddr),
        .rdata (tp_rdata)
    );

    assign status.clearing = (state_reg == ST_CLEAR);
    assign succ_valid      = out_vld_reg;
    assign succ            = out_reg;

    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !q_pop)
        else $error("queue popped during obstacle sweep");

    a_pend_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(state_reg == ST_SCAN))
        else $error("trajectory compare pending outside scan");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (succ_valid && !succ.found) |-> succ.last)
        else $error("not-found result without last");

    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && held_vld_reg && !out_free) |=> (state_reg == ST_EMIT))
        else $error("successor pushed into a full output register");

endmodule

FILE: design/space_time_grid_successor_expander_unit.sv
// ----------------------------------------------------------------------------
// space_time_grid_successor_expander_unit
// Expands one node of a 3D space-time grid search into its free successors.
// ----------------------------------------------------------------------------
//  channel | signals                               | direction | item
//  node    | node_valid, node_ready, node          | in        | load or expand
//  succ    | succ_valid, succ_ready, succ          | out       | one successor
//  apb     | psel penable pwrite paddr pwdata ...  | in        | register write
//
//  After reset all GRID_SIDE^3 obstacle map entries (4096 by default) are
//  swept to free; node_ready stays low until the sweep is done.
//  Load items are executed by the back while it is idle. An expand tries
//  the seven moves in turn: each in-grid move reads the obstacle map, and a
//  free one scans each agent's window of up to 2*window_delta+1
//  trajectory points (one RAM read per cycle); agents without one are skipped.
//  A two-entry queue lets the front keep accepting while the back scans;
//  each successor waits in a one-deep hold stage so last can be set,
//  and the output register stalls only the back on succ_ready.
// ----------------------------------------------------------------------------
module space_time_grid_successor_expander_unit
    import stcx_pkg::*;
#(
    parameter int GRID_SIDE  = GRID_SIDE_DEF,
    parameter int MAX_AGENTS = MAX_AGENTS_DEF,
    parameter int TRAJ_LEN   = TRAJ_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              node_valid,
    output logic              node_ready,
    input  in_item_t          node,
    output logic              succ_valid,
    input  logic              succ_ready,
    output out_item_t         succ,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t         cfg_reg, cfg_next;
    reg_idx_t     reg_idx;
    logic         cfg_wr;
    logic         q_full;
    logic         push;
    cmd_t         push_cmd;
    logic         q_pop;
    logic         head_valid;
    cmd_t         head_cmd;
    back_status_t status;

    // ---------------- register file ----------------
    // registers sit on word addresses; the low two address bits are ignored
    assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_SIZE_X: cfg_next.size_x       = pwdata[SIZE_W-1:0];
                REG_SIZE_Y: cfg_next.size_y       = pwdata[SIZE_W-1:0];
                REG_SIZE_Z: cfg_next.size_z       = pwdata[SIZE_W-1:0];
                REG_DELTA:  cfg_next.window_delta = pwdata[DELTA_W-1:0];
                REG_AGENTS: cfg_next.agent_count  = pwdata[ACNT_W-1:0];
                REG_GOAL_X: cfg_next.goal_x       = pwdata[COORD_W-1:0];
                REG_GOAL_Y: cfg_next.goal_y       = pwdata[COORD_W-1:0];
                REG_GOAL_Z: cfg_next.goal_z       = pwdata[COORD_W-1:0];
                default:    cfg_next              = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SIZE_X: prdata = APB_DW'(cfg_reg.size_x);
            REG_SIZE_Y: prdata = APB_DW'(cfg_reg.size_y);
            REG_SIZE_Z: prdata = APB_DW'(cfg_reg.size_z);
            REG_DELTA:  prdata = APB_DW'(cfg_reg.window_delta);
            REG_AGENTS: prdata = APB_DW'(cfg_reg.agent_count);
            REG_GOAL_X: prdata = APB_DW'(cfg_reg.goal_x);
            REG_GOAL_Y: prdata = APB_DW'(cfg_reg.goal_y);
            REG_GOAL_Z: prdata = APB_DW'(cfg_reg.goal_z);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size_x       <= SIZE_W'(16);
            cfg_reg.size_y       <= SIZE_W'(16);
            cfg_reg.size_z       <= SIZE_W'(16);
            cfg_reg.window_delta <= DELTA_W'(1);
            cfg_reg.agent_count  <= '0;
            cfg_reg.goal_x       <= '0;
            cfg_reg.goal_y       <= '0;
            cfg_reg.goal_z       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- front: accept and classify ----------------
    stcx_front #(
        .GRID_SIDE  (GRID_SIDE),
        .MAX_AGENTS (MAX_AGENTS),
        .TRAJ_LEN   (TRAJ_LEN)
    ) u_front (
        .node_valid (node_valid),
        .node_ready (node_ready),
        .node       (node),
        .q_full     (q_full),
        .status     (status),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // ---------------- decoupling queue ----------------
    stcx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // ---------------- back: memories, scan, output ----------------
    stcx_back #(
        .GRID_SIDE  (GRID_SIDE),
        .MAX_AGENTS (MAX_AGENTS),
        .TRAJ_LEN   (TRAJ_LEN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (head_valid),
        .q_cmd      (head_cmd),
        .q_pop      (q_pop),
        .status     (status),
        .succ_valid (succ_valid),
        .succ_ready (succ_ready),
        .succ       (succ)
    );

endmodule
